// ===== hw/rtl/sc2a_pkg.sv =====
// Shared types, scancode constants and translation tables for the scancode decoder.
package sc2a_pkg;

    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
    localparam int unsigned TABLE_LEN      = 58;
    localparam logic [6:0] CASE_FLIP       = 7'd32;

    localparam logic MODE_SCANCODE = 1'b0;
    localparam logic MODE_READ     = 1'b1;

    localparam logic [6:0] PLAIN_MAP [TABLE_LEN] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam logic [6:0] SHIFTED_MAP [TABLE_LEN] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    typedef struct packed {
        logic       push;
        logic [6:0] ch;
    } push_req_t;

    typedef struct packed {
        logic read_valid;
        logic key_waiting;
        logic dropped;
    } ring_status_t;

    function automatic logic [6:0] translate(input logic [7:0] code, input logic shift,
                                             input logic caps);
        logic [6:0] c;
        c = 7'd0;
        if (code < 8'(TABLE_LEN)) begin
            c = shift ? SHIFTED_MAP[code[5:0]] : PLAIN_MAP[code[5:0]];
            if (caps) begin
                if (c >= 7'h61 && c <= 7'h7A) begin
                    c = c - CASE_FLIP;
                end else if (c >= 7'h41 && c <= 7'h5A) begin
                    c = c + CASE_FLIP;
                end
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/sc2a_decode.sv =====
// Shift and caps tracking and scancode translation into push requests.
module sc2a_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic                mode,
    input  logic [7:0]          scancode,
    output sc2a_pkg::push_req_t push_req
);
    import sc2a_pkg::*;

    logic shift_reg, shift_next;
    logic caps_reg, caps_next;
    logic [6:0] ch;

    assign ch = translate(scancode, shift_reg, caps_reg);

    always_comb begin
        shift_next    = shift_reg;
        caps_next     = caps_reg;
        push_req.push = 1'b0;
        push_req.ch   = ch;
        if (accept && mode == MODE_SCANCODE) begin
            priority if (scancode == SC_LSHIFT_MAKE || scancode == SC_RSHIFT_MAKE) begin
                shift_next = 1'b1;
            end else if (scancode == SC_LSHIFT_BREAK || scancode == SC_RSHIFT_BREAK) begin
                shift_next = 1'b0;
            end else if (scancode == SC_CAPS_MAKE) begin
                caps_next = !caps_reg;
            end else if (!scancode[7]) begin
                push_req.push = (ch != 7'd0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= 1'b0;
            caps_reg  <= 1'b0;
        end else begin
            shift_reg <= shift_next;
            caps_reg  <= caps_next;
        end
    end

endmodule

// ===== hw/rtl/sc2a_ring.sv =====
// Character ring: pointers, full and empty logic, and the character memory.
module sc2a_ring #(
    parameter int DEPTH = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic                   mode,
    input  sc2a_pkg::push_req_t    push_req,
    output sc2a_pkg::ring_status_t status,
    output logic [6:0]             rdata
);
    import sc2a_pkg::*;

    localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;

    logic [6:0]    char_mem [DEPTH];
    logic [6:0]    rdata_reg;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] wr_inc, rd_inc;
    logic          empty, full, rd_en, wr_en;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        if (p == PW'(DEPTH - 1)) begin
            return '0;
        end
        return p + PW'(1);
    endfunction

    assign wr_inc = ring_next(wr_ptr_reg);
    assign rd_inc = ring_next(rd_ptr_reg);
    assign empty  = (rd_ptr_reg == wr_ptr_reg);
    assign full   = (wr_inc == rd_ptr_reg);
    assign rd_en  = accept && mode == MODE_READ && !empty;
    assign wr_en  = push_req.push && !full;

    always_comb begin
        rd_ptr_next        = rd_en ? rd_inc : rd_ptr_reg;
        wr_ptr_next        = wr_en ? wr_inc : wr_ptr_reg;
        status.read_valid  = rd_en;
        status.dropped     = push_req.push && full;
        status.key_waiting = (rd_ptr_next != wr_ptr_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            char_mem[wr_ptr_reg] <= push_req.ch;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= char_mem[rd_ptr_reg];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/scancode_to_ascii_fifo_core.sv =====
// Top level of the set-1 scancode to ASCII decoder with its character ring.
//
//  Channel | Direction | Contents
//  --------+-----------+-------------------------------------------------------
//  s_      | in        | tuser: mode; tdata: scancode
//  m_      | out       | tdata: read_valid, read_char, key_waiting, dropped
//
// One item is accepted per cycle while the result side keeps up.
// An accepted item's result passes first through the registered read of the
// character memory, then through the output register.
// Reset clears the pointers and the shift and caps flags; the memory is not cleared.
// A stalled output holds the memory stage, and the input stalls only when both are full.
module scancode_to_ascii_fifo_core #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scancode
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] read_valid, [7:1] read_char, [8] key_waiting,
                                   // [9] dropped, [15:10] zero
);
    import sc2a_pkg::*;

    logic         accept;
    push_req_t    push_req;
    ring_status_t status;
    logic [6:0]   rdata;

    logic         s1_valid_reg, s1_valid_next;
    ring_status_t s1_status_reg;
    logic         s1_adv;
    logic         m_valid_reg, m_valid_next;
    logic [15:0]  m_data_reg;

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    sc2a_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .mode     (s_tuser),
        .scancode (s_tdata),
        .push_req (push_req)
    );

    sc2a_ring #(
        .DEPTH (BUFFER_DEPTH)
    ) u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .mode     (s_tuser),
        .push_req (push_req),
        .status   (status),
        .rdata    (rdata)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_status_reg <= status;
        end
        if (s1_adv) begin
            m_data_reg <= {6'd0, s1_status_reg.dropped, s1_status_reg.key_waiting,
                           s1_status_reg.read_valid ? rdata : 7'd0,
                           s1_status_reg.read_valid};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== hw/rtl/sc2a_checker.sv =====
// Port-level checks on the scancode decoder's results, bound to the top level.
module sc2a_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A character is only reported together with a successful read.
    a_char_needs_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[7:1] == 7'd0)
        else $error("read_char nonzero without read_valid");

    // Only nonzero characters are ever stored, so a pop never yields zero.
    a_read_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[7:1] != 7'd0)
        else $error("read_valid with a zero character");

    // A drop means the ring was full, so a key is still waiting afterwards.
    a_drop_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> m_tdata[8] && !m_tdata[0])
        else $error("dropped without key_waiting or together with a read");

    // A result that is not taken stays on the bus unchanged.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or vanished while stalled");

    // The input only stalls while a result is waiting and not taken.
    a_ready_when_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("s_tready low while the result side can move");

endmodule

bind scancode_to_ascii_fifo_core sc2a_checker u_sc2a_checker (.*);
